// File: hdl/msc_pkg.sv
// Shared types and constants for the MIPS subset core.
`default_nettype none
package msc_pkg;
    localparam int MemBytes = 16384;
    localparam int MemAw = $clog2(MemBytes);

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J = 6'd2;
    localparam logic [5:0] OP_JAL = 6'd3;
    localparam logic [5:0] OP_BEQ = 6'd4;
    localparam logic [5:0] OP_BNE = 6'd5;
    localparam logic [5:0] OP_ADDI = 6'd8;
    localparam logic [5:0] OP_SLTI = 6'd10;
    localparam logic [5:0] OP_ANDI = 6'd12;
    localparam logic [5:0] OP_ORI = 6'd13;
    localparam logic [5:0] OP_LUI = 6'd15;
    localparam logic [5:0] OP_LB = 6'd32;
    localparam logic [5:0] OP_LW = 6'd35;
    localparam logic [5:0] OP_SB = 6'd40;
    localparam logic [5:0] OP_SW = 6'd43;

    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_JR = 6'd8;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI = 6'd16;
    localparam logic [5:0] FN_MFLO = 6'd18;
    localparam logic [5:0] FN_MULT = 6'd24;
    localparam logic [5:0] FN_DIV = 6'd26;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR = 6'd37;
    localparam logic [5:0] FN_XOR = 6'd38;
    localparam logic [5:0] FN_NOR = 6'd39;
    localparam logic [5:0] FN_SLT = 6'd42;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [0:0] REG_START_PC = 1'd0;
    localparam logic [0:0] REG_STACK_INIT = 1'd1;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_md_rsp;
endpackage
`default_nettype wire

// File: hdl/msc_muldiv.sv
// Iterative signed multiply / divide unit, one bit per cycle.
`default_nettype none
module msc_muldiv import msc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_md_req i_req,
    output t_md_rsp      o_rsp
);
    logic        r_busy, r_div, r_neg_q, r_neg_r, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_acc;
    logic [31:0] r_opb;
    logic [32:0] w_trial;
    logic [31:0] w_q, w_r;

    assign w_trial = {r_acc[63:31]} - {1'b0, r_opb};
    assign w_q = r_neg_q ? (32'd0 - r_acc[31:0]) : r_acc[31:0];
    assign w_r = r_neg_r ? (32'd0 - r_acc[63:32]) : r_acc[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div <= i_req.is_div;
                r_cnt <= 6'd0;
                if (i_req.is_div) begin
                    r_acc <= {32'd0, i_req.a[31] ? 32'd0 - i_req.a : i_req.a};
                    r_opb <= i_req.b[31] ? 32'd0 - i_req.b : i_req.b;
                    r_neg_q <= i_req.a[31] ^ i_req.b[31];
                    r_neg_r <= i_req.a[31];
                end else begin
                    r_acc <= {32'd0, i_req.b};
                    r_opb <= i_req.a;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_div) begin
                    if (!w_trial[32])
                        r_acc <= {w_trial[31:0], r_acc[30:0], 1'b1};
                    else
                        r_acc <= {r_acc[62:0], 1'b0};
                end else begin
                    // signed shift-add: last multiplier bit carries negative weight
                    logic [32:0] s;
                    logic [32:0] addend;
                    addend = {r_opb[31], r_opb};
                    if (r_acc[0])
                        s = (r_cnt == 6'd31) ? {r_acc[63], r_acc[63:32]} - addend
                                             : {r_acc[63], r_acc[63:32]} + addend;
                    else
                        s = {r_acc[63], r_acc[63:32]};
                    r_acc <= {s, r_acc[31:1]};
                end
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi = (r_div && !r_done) ? 32'd0 : (r_div ? w_r : r_acc[63:32]);
    assign o_rsp.lo = r_div ? w_q : r_acc[31:0];
endmodule
`default_nettype wire

// File: hdl/mips_subset_core_unit.sv
// Multicycle MIPS subset core top level: sequencer, memory, register file.
// Load byte, register read and any command to a halted core go idle, done, output.
// Exec fetches the word byte by byte and executes, then runs the memory state for
// lb, lw, sb, sw or waits on the mult/div unit for mult and div (not div by zero).
// One command at a time; the next is taken the cycle after the result transfer.
// Reset is synchronous; a clearing pass then zeroes all memory, accepting no command.
`default_nettype none
module mips_subset_core_unit import msc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata, // cmd, addr, byte_data, reg_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [127:0]     m_axis_tdata, // pc, service_code, service_arg, read_value
    output logic [1:0]       m_axis_tuser, // halted, service_request
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001, S_IDLE = 8'b00000010, S_FETCH = 8'b00000100,
        S_EXEC  = 8'b00001000, S_MEM  = 8'b00010000, S_MD   = 8'b00100000,
        S_DONE  = 8'b01000000, S_OUT  = 8'b10000000
    } t_state;

    t_state r_state;
    logic [7:0]  mem [MemBytes];
    logic [7:0]  r_rdata;
    logic [31:0] regs [32];
    logic [MemAw:0] r_clr;
    logic [13:0] r_start_pc, r_stack_init;
    logic [31:0] r_pc, r_hi, r_lo, r_ir, r_ea, r_sd, r_ld;
    logic        r_halt, r_req, r_store, r_word;
    logic [31:0] r_code, r_arg, r_rv;
    logic [2:0]  r_k;
    t_md_req     w_md;
    t_md_rsp     w_mdr;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STACK_INIT) ? {18'd0, r_stack_init}
                                                 : {18'd0, r_start_pc};

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] a, b, se, imm, npc;
    assign op = r_ir[31:26]; assign fn = r_ir[5:0];
    assign rs = r_ir[25:21]; assign rt = r_ir[20:16];
    assign rd = r_ir[15:11]; assign sh = r_ir[10:6];
    assign imm = {16'd0, r_ir[15:0]};
    assign se = {{16{r_ir[15]}}, r_ir[15:0]};
    assign a = regs[rs]; assign b = regs[rt];
    assign npc = r_pc + 32'd4;

    logic [MemAw-1:0] w_maddr;
    logic [31:0] w_bad;
    always_comb begin
        w_bad = (r_state == S_FETCH) ? r_pc + {29'd0, r_k} : r_ea + {29'd0, r_k};
        w_maddr = w_bad[MemAw-1:0];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {r_rv, r_arg, r_code, r_pc};
    assign m_axis_tuser = {r_req, r_halt};
    assign w_md.a = a; assign w_md.b = b;
    assign w_md.is_div = (fn == FN_DIV);
    assign w_md.start = (r_state == S_EXEC) && op == OP_SPECIAL &&
                        (fn == FN_MULT || (fn == FN_DIV && b != 32'd0));

    msc_muldiv u_md (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_md), .o_rsp(w_mdr));

    // memory port
    logic mem_we;
    logic [7:0] mem_wd;
    logic [MemAw-1:0] mem_wa;
    always_comb begin
        mem_we = 1'b0; mem_wd = r_sd[7:0]; mem_wa = w_maddr;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1; mem_wd = 8'd0; mem_wa = r_clr[MemAw-1:0];
        end else if (r_state == S_IDLE && s_axis_tvalid && s_axis_tdata[1:0] == CMD_LOAD) begin
            mem_we = 1'b1; mem_wd = s_axis_tdata[23:16]; mem_wa = s_axis_tdata[15:2];
        end else if (r_state == S_MEM && r_store) begin
            mem_we = 1'b1;
            case (r_k[1:0])
                2'd0: mem_wd = r_sd[7:0];
                2'd1: mem_wd = r_sd[15:8];
                2'd2: mem_wd = r_sd[23:16];
                default: mem_wd = r_sd[31:24];
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[w_maddr];
    end

    logic rf_we;
    logic [4:0] rf_wa;
    logic [31:0] rf_wd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
            regs[29] <= 32'd12284;
        end else begin
            if (rf_we && rf_wa != 5'd0) regs[rf_wa] <= rf_wd;
            if (cfg_wr && paddr[2] == REG_STACK_INIT) regs[29] <= {18'd0, pwdata[13:0]};
        end
    end

    logic [31:0] ld_full;
    assign ld_full = {r_rdata, r_ld[31:8]};

    always_comb begin
        rf_we = 1'b0; rf_wa = rt; rf_wd = 32'd0;
        if (r_state == S_EXEC) begin
            rf_we = 1'b1;
            unique case (op)
                OP_SPECIAL: begin
                    rf_wa = rd;
                    case (fn)
                        FN_SLL: rf_wd = b << sh;
                        FN_SRL: rf_wd = b >> sh;
                        FN_MFHI: rf_wd = r_hi;
                        FN_MFLO: rf_wd = r_lo;
                        FN_ADD: rf_wd = a + b;
                        FN_SUB: rf_wd = a - b;
                        FN_AND: rf_wd = a & b;
                        FN_OR: rf_wd = a | b;
                        FN_XOR: rf_wd = a ^ b;
                        FN_NOR: rf_wd = ~(a | b);
                        FN_SLT: rf_wd = {31'd0, $signed(a) < $signed(b)};
                        default: rf_we = 1'b0;
                    endcase
                end
                OP_JAL: begin rf_wa = 5'd31; rf_wd = npc; end
                OP_ADDI: rf_wd = a + se;
                OP_SLTI: rf_wd = {31'd0, $signed(a) < $signed(se)};
                OP_ANDI: rf_wd = a & imm;
                OP_ORI: rf_wd = a | imm;
                OP_LUI: rf_wd = {r_ir[15:0], 16'd0};
                default: rf_we = 1'b0;
            endcase
        end else if (r_state == S_MEM && !r_store && r_k == (r_word ? 3'd4 : 3'd1)) begin
            rf_we = 1'b1;
            rf_wd = r_word ? ld_full : {{24{r_rdata[7]}}, r_rdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0;
            r_start_pc <= 14'd12288; r_stack_init <= 14'd12284;
            r_pc <= 32'd12288; r_halt <= 1'b0; r_hi <= '0; r_lo <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_START_PC) begin
                r_start_pc <= pwdata[13:0]; r_pc <= {18'd0, pwdata[13:0]};
            end
            if (cfg_wr && paddr[2] == REG_STACK_INIT) r_stack_init <= pwdata[13:0];
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + (MemAw+1)'(1);
                    if (r_clr == (MemAw+1)'(MemBytes - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_req <= 1'b0; r_code <= '0; r_arg <= '0; r_rv <= '0;
                    r_k <= 3'd0;
                    if (s_axis_tdata[1:0] == CMD_EXEC && !r_halt) r_state <= S_FETCH;
                    else r_state <= S_DONE;
                    if (s_axis_tdata[1:0] == CMD_READ) r_rv <= regs[s_axis_tdata[28:24]];
                end
                S_FETCH: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) r_ir <= {r_rdata, r_ir[31:8]};
                    if (r_k == 3'd4) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pc <= npc; r_k <= 3'd0;
                    r_ea <= a + se; r_sd <= b;
                    r_store <= (op == OP_SB || op == OP_SW);
                    r_word <= (op == OP_LW || op == OP_SW);
                    r_state <= S_DONE;
                    unique case (op)
                        OP_SPECIAL: begin
                            if (fn == FN_JR) r_pc <= a;
                            if (fn == FN_SYSCALL) begin
                                r_code <= regs[2]; r_arg <= regs[4];
                                if (regs[2] == 32'd1 || regs[2] == 32'd4 ||
                                    regs[2] == 32'd5 || regs[2] == 32'd8)
                                    r_req <= 1'b1;
                                else r_halt <= 1'b1;
                            end
                            if (w_md.start) r_state <= S_MD;
                        end
                        OP_J, OP_JAL: r_pc <= {npc[31:28], r_ir[25:0], 2'b00};
                        OP_BEQ: if (a == b) r_pc <= npc + (se << 2);
                        OP_BNE: if (a != b) r_pc <= npc + (se << 2);
                        OP_LB, OP_LW, OP_SB, OP_SW: r_state <= S_MEM;
                        default: ;
                    endcase
                end
                S_MEM: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) r_ld <= ld_full;
                    if (r_store ? (r_k == (r_word ? 3'd3 : 3'd0))
                                : (r_k == (r_word ? 3'd4 : 3'd1)))
                        r_state <= S_DONE;
                end
                S_MD: if (w_mdr.done) begin
                    r_hi <= w_mdr.hi; r_lo <= w_mdr.lo; r_state <= S_DONE;
                end
                S_DONE: r_state <= S_OUT;
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/msc_checker.sv
// Port-level checker for the MIPS subset core, bound to the top level.
`default_nettype none
module msc_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1] |-> 1'b0)
        else $error("halt and service together");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind mips_subset_core_unit msc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

// File: dv/msc_checker.sv
// Checker for the MIPS subset core: watches the streams and the register port, predicts and compares.
module msc_tb_checker import msc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] pc;
        logic        halted;
        logic        req;
        logic [31:0] code;
        logic [31:0] arg;
        logic [31:0] rv;
    } t_status;

    t_status     status_q[$];
    logic [7:0]  mem [MemBytes];
    logic [31:0] rf [32];
    logic [31:0] hi_q, lo_q, pc_q;
    logic        halt_q;
    int          errors;

    function automatic logic [7:0] mem_rd(logic [31:0] a);
        logic [MemAw-1:0] idx;
        idx = a[MemAw-1:0];
        return mem[idx];
    endfunction

    function automatic void mem_wr(logic [31:0] a, logic [7:0] v);
        logic [MemAw-1:0] idx;
        idx = a[MemAw-1:0];
        mem[idx] = v;
    endfunction

    function automatic logic [31:0] word_rd(logic [31:0] a);
        return {mem_rd(a + 3), mem_rd(a + 2), mem_rd(a + 1), mem_rd(a)};
    endfunction

    function automatic void reg_wr(logic [4:0] r, logic [31:0] v);
        if (r != 5'd0) rf[r] = v;
    endfunction

    function automatic void run_instr(ref t_status st);
        logic [31:0] ir, a, b, imm, se, npc, ea, v;
        logic [7:0]  bv;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        longint      x, y, p;
        ir  = word_rd(pc_q);
        op  = ir[31:26];
        rs  = ir[25:21];
        rt  = ir[20:16];
        rd  = ir[15:11];
        sh  = ir[10:6];
        fn  = ir[5:0];
        imm = {16'd0, ir[15:0]};
        se  = {{16{ir[15]}}, ir[15:0]};
        a   = rf[rs];
        b   = rf[rt];
        npc = pc_q + 32'd4;
        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_SLL: reg_wr(rd, b << sh);
                    FN_SRL: reg_wr(rd, b >> sh);
                    FN_JR: npc = a;
                    FN_SYSCALL: begin
                        st.code = rf[2];
                        st.arg  = rf[4];
                        if (rf[2] == 1 || rf[2] == 4 || rf[2] == 5 || rf[2] == 8) st.req = 1'b1;
                        else halt_q = 1'b1;
                    end
                    FN_MFHI: reg_wr(rd, hi_q);
                    FN_MFLO: reg_wr(rd, lo_q);
                    FN_MULT: begin
                        p = longint'($signed(a)) * longint'($signed(b));
                        hi_q = p[63:32];
                        lo_q = p[31:0];
                    end
                    FN_DIV: begin
                        if (b != 0) begin
                            x = longint'($signed(a));
                            y = longint'($signed(b));
                            p = x / y;
                            lo_q = p[31:0];
                            p = x % y;
                            hi_q = p[31:0];
                        end
                    end
                    FN_ADD: reg_wr(rd, a + b);
                    FN_SUB: reg_wr(rd, a - b);
                    FN_AND: reg_wr(rd, a & b);
                    FN_OR:  reg_wr(rd, a | b);
                    FN_XOR: reg_wr(rd, a ^ b);
                    FN_NOR: reg_wr(rd, ~(a | b));
                    FN_SLT: reg_wr(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
                    default: ;
                endcase
            end
            OP_J: npc = {npc[31:28], ir[25:0], 2'b00};
            OP_JAL: begin
                reg_wr(5'd31, npc);
                npc = {npc[31:28], ir[25:0], 2'b00};
            end
            OP_BEQ: if (a == b) npc = npc + (se << 2);
            OP_BNE: if (a != b) npc = npc + (se << 2);
            OP_ADDI: reg_wr(rt, a + se);
            OP_SLTI: reg_wr(rt, ($signed(a) < $signed(se)) ? 32'd1 : 32'd0);
            OP_ANDI: reg_wr(rt, a & imm);
            OP_ORI:  reg_wr(rt, a | imm);
            OP_LUI:  reg_wr(rt, imm << 16);
            OP_LB: begin
                bv = mem_rd(a + se);
                v = {{24{bv[7]}}, bv};
                reg_wr(rt, v);
            end
            OP_LW: reg_wr(rt, word_rd(a + se));
            OP_SB: mem_wr(a + se, b[7:0]);
            OP_SW: begin
                ea = a + se;
                mem_wr(ea, b[7:0]);
                mem_wr(ea + 1, b[15:8]);
                mem_wr(ea + 2, b[23:16]);
                mem_wr(ea + 3, b[31:24]);
            end
            default: ;
        endcase
        rf[0] = '0;
        pc_q  = npc;
    endfunction

    function automatic t_status predict_status(logic [31:0] d);
        t_status st;
        st = '{pc: '0, halted: 1'b0, req: 1'b0, code: '0, arg: '0, rv: '0};
        case (d[1:0])
            CMD_LOAD: mem_wr({18'd0, d[15:2]}, d[23:16]);
            CMD_EXEC: if (!halt_q) run_instr(st);
            CMD_READ: st.rv = rf[d[28:24]];
            default: ;
        endcase
        st.pc     = pc_q;
        st.halted = halt_q;
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_status     got, want;
        logic [127:0] wide;
        if (!i_rst_n) begin
            foreach (mem[i]) mem[i] = '0;
            foreach (rf[i]) rf[i] = '0;
            rf[29] = 32'd12284;
            hi_q   = '0;
            lo_q   = '0;
            pc_q   = 32'd12288;
            halt_q = 1'b0;
            status_q.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_START_PC) pc_q = {18'd0, pwdata[13:0]};
                else rf[29] = {18'd0, pwdata[13:0]};
            end
            if (s_tvalid && s_tready) status_q.push_back(predict_status(s_tdata));
            if (m_tvalid && m_tready) begin
                wide       = m_tdata;
                got.pc     = wide[31:0];
                got.code   = wide[63:32];
                got.arg    = wide[95:64];
                got.rv     = wide[127:96];
                got.halted = m_tuser[0];
                got.req    = m_tuser[1];
                if (status_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result transfer pc=%h", got.pc);
                end else begin
                    want = status_q.pop_front();
                    if (got.pc !== want.pc || got.halted !== want.halted ||
                        got.req !== want.req || got.code !== want.code ||
                        got.arg !== want.arg || got.rv !== want.rv) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp pc=%h h=%b r=%b c=%h a=%h v=%h",
                                      " got pc=%h h=%b r=%b c=%h a=%h v=%h"},
                                want.pc, want.halted, want.req, want.code, want.arg, want.rv,
                                got.pc, got.halted, got.req, got.code, got.arg, got.rv);
                    end
                end
            end
        end
        o_pending <= status_q.size();
        o_errors  <= errors;
    end
endmodule

// File: dv/tb_top.sv
// Testbench top for the MIPS subset core: clock, reset, stimulus and verdict.
module tb_top import msc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int IdleLimit = 100000;
    localparam int HoldCycles = 400;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int errors, pending;
    int n_sent = 0, n_progs = 0;
    int send_idle = 20, recv_idle = 64;
    bit hold_req = 1'b0, hold_done = 1'b0;

    mips_subset_core_unit u_top (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    msc_tb_checker u_checker (
        .i_clk, .i_rst_n, .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser), .psel, .penable, .pwrite,
        .paddr, .pwdata, .pready, .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // receiver, with one long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HoldCycles) hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial begin
        int idle_cnt;
        idle_cnt = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= IdleLimit) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] jtype(logic [5:0] op, logic [31:0] target);
        return {op, target[27:2]};
    endfunction

    function automatic logic [4:0] pick_reg();
        logic [4:0] pool [10] = '{0, 1, 2, 3, 4, 5, 8, 29, 31, 6};
        if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
        return pool[$urandom_range(0, 9)];
    endfunction

    // pick_dst never returns v0, so a stray syscall sees the service code unless a raw random word overwrote v0
    function automatic logic [4:0] pick_dst();
        logic [4:0] r;
        r = pick_reg();
        return (r == 5'd2) ? 5'd3 : r;
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_instr(logic [31:0] base);
        logic [5:0]  fns [15] = '{FN_SLL, FN_SRL, FN_JR, FN_SYSCALL, FN_MFHI, FN_MFLO,
                                  FN_MULT, FN_DIV, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR,
                                  FN_NOR, FN_SLT};
        logic [5:0]  ops [13] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_ANDI,
                                  OP_ORI, OP_LUI, OP_LB, OP_LW, OP_SB, OP_SW};
        logic [5:0]  op;
        logic [4:0]  rs;
        int          k;
        k = $urandom_range(0, 28);
        if (k < 15) begin
            if (fns[k] == FN_JR) return rtype(($urandom_range(0, 1) ? 5'd31 : pick_reg()),
                                              5'd0, 5'd0, 5'd0, FN_JR);
            return rtype(pick_reg(), pick_reg(), pick_dst(), 5'($urandom), fns[k]);
        end
        if (k == 28) return 32'($urandom);
        op = ops[k - 15];
        if (op == OP_J || op == OP_JAL) return jtype(op, base + 4 * $urandom_range(0, 12));
        if (op == OP_BEQ || op == OP_BNE)
            return itype(op, pick_reg(), pick_reg(), 16'($signed($urandom_range(0, 8)) - 3));
        rs = (op == OP_LB || op == OP_LW || op == OP_SB || op == OP_SW) ?
             ($urandom_range(0, 1) ? 5'd29 : pick_reg()) : pick_reg();
        return itype(op, rs, pick_dst(), pick_imm());
    endfunction

    task automatic send(logic [1:0] cmd, logic [13:0] addr, logic [7:0] data, logic [4:0] idx);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, idx, data, addr, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        if (n_sent == 700) begin
            send_idle = 64;
            recv_idle = 20;
        end
        if (n_sent == 1000) hold_req = 1'b1;
        if (n_sent == 1400) begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic put_word(logic [31:0] a, logic [31:0] w);
        for (int i = 0; i < 4; i++) send(CMD_LOAD, 14'(a + i), w[8*i +: 8], 5'($urandom));
    endtask

    task automatic drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_program(logic [31:0] base, ref logic [31:0] prog[$], input int n_exec);
        foreach (prog[i]) put_word(base + 4 * i, prog[i]);
        for (int i = 0; i < n_exec; i++) begin
            send(CMD_EXEC, 14'($urandom), 8'($urandom), 5'($urandom));
            case ($urandom_range(0, 9))
                0: send(CMD_READ, 14'($urandom), 8'($urandom), 5'($urandom));
                1: send(CMD_NONE, 14'($urandom), 8'($urandom), 5'($urandom));
                2: send(CMD_LOAD, 14'($urandom), 8'($urandom), 5'($urandom));
                default: ;
            endcase
        end
        for (int i = 0; i < 4; i++) send(CMD_READ, 14'($urandom), 8'($urandom), 5'($urandom));
        n_progs++;
    endtask

    initial begin
        logic [31:0] prog[$];
        logic [31:0] base;
        logic [15:0] svc [4] = '{1, 4, 5, 8};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edge arithmetic, wrapped addresses, r0, jumps, unknown opcode
        base = 32'd12288;
        prog = '{itype(OP_ADDI, 0, 2, 4), itype(OP_LUI, 0, 8, 16'h8000),
                 itype(OP_ADDI, 0, 9, 16'hffff), rtype(8, 9, 0, 0, FN_DIV),
                 rtype(0, 0, 10, 0, FN_MFLO), rtype(0, 0, 11, 0, FN_MFHI),
                 rtype(8, 0, 0, 0, FN_DIV), rtype(8, 8, 0, 0, FN_MULT),
                 rtype(0, 0, 12, 0, FN_MFHI), rtype(8, 8, 13, 0, FN_ADD),
                 rtype(0, 8, 14, 0, FN_SUB), itype(OP_ORI, 0, 15, 16'hffff),
                 itype(OP_ANDI, 9, 16, 16'hffff), itype(OP_SLTI, 8, 17, 1),
                 rtype(9, 0, 18, 0, FN_SLT), rtype(0, 9, 19, 31, FN_SRL),
                 rtype(0, 9, 20, 31, FN_SLL), rtype(0, 0, 21, 0, FN_NOR),
                 itype(OP_ADDI, 0, 0, 5), itype(OP_SW, 0, 9, 16'hffff),
                 itype(OP_LW, 0, 22, 16'hffff), itype(OP_LB, 0, 23, 16'hffff),
                 itype(OP_SB, 29, 8, 0), rtype(0, 0, 0, 0, FN_SYSCALL),
                 itype(OP_BEQ, 0, 0, 1), 32'd0, itype(OP_BNE, 0, 0, 4),
                 jtype(OP_JAL, base + 4 * 29), jtype(OP_J, base + 4 * 30),
                 rtype(31, 0, 0, 0, FN_JR), 32'hfc00_0000};
        write_reg(REG_STACK_INIT, 32'd16383);
        run_program(base, prog, 34);

        // random programs until the item budget is spent
        while (n_sent < 2000) begin
            case ($urandom_range(0, 5))
                0: base = 32'd0;
                1: base = 32'd16380;
                default: base = 32'($urandom_range(0, 4095)) << 2;
            endcase
            write_reg(REG_START_PC, base | 32'($urandom_range(0, 3) << 14));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_STACK_INIT, $urandom_range(0, 1) ? 32'($urandom) :
                          ($urandom_range(0, 1) ? 32'd0 : 32'd16383));
            prog = '{itype(OP_ADDI, 0, 2, svc[$urandom_range(0, 3)])};
            repeat ($urandom_range(4, 12)) prog.push_back(random_instr(base));
            run_program(base, prog, prog.size() + $urandom_range(0, 4));
        end

        // exit syscall, then commands on a halted core
        write_reg(REG_START_PC, 32'd1024);
        prog = '{itype(OP_ADDI, 0, 2, 10), itype(OP_ADDI, 0, 4, 16'hffff),
                 rtype(0, 0, 0, 0, FN_SYSCALL)};
        run_program(32'd1024, prog, 5);

        drain();
        repeat (60) @(posedge i_clk);
        $display("ran %0d input transfers over %0d programs, with long output hold-off",
                 n_sent, n_progs);
        $display("covered every opcode and funct, syscalls, halt and register settings");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
